### rtl/assert_macros.svh
// Assertion macros for the RTL of the block bitmap allocator.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/bba_pkg.sv
// Package of the block bitmap allocator: field widths, defaults and codes.
// No dependencies; imported by the allocator top level.
package bba_pkg;

  // Default block count of the bitmap
  localparam int unsigned NUM_BLOCKS_DEF = 4096;

  // Bitmap word and field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned BLK_W   = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned WIDX_W  = BLK_W - BIT_W;

  // Reach of the 12 bit block fields
  localparam int unsigned FIELD_LIMIT = 4096;

  // Reset value of the block count register
  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = CFG_W'(4096);

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

endpackage

### rtl/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the usage bitmap of the allocator.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/block_bitmap_allocator_top.sv
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg, bba_ram and assert_macros.svh.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  request  | in_valid_i, in_stall_o, cmd_i,           | in
//           | block_number_i                           |
//  result   | out_valid_o, out_stall_i,                | out
//           | allocated_block_o, status_o              |
//  config   | cfg_we_i, cfg_wdata_i (block count)      | in
//
// A free passes through S_IDLE, S_EVAL and S_RESP; a rejected request (zero
// count, out of range) goes from S_IDLE straight to S_RESP. An allocate scans
// up to ceil(count/32) words in S_EVAL, one a cycle through the single bitmap RAM read port.
// After reset a clearing pass writes zero to every bitmap word, one per cycle
// (128 words at the default size); requests stall during that pass.
// The result sits in an output register, so a new request is taken while
// the previous result is stalled; a request stalls while a request is in
// flight and while the next result waits for that register to empty.
module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // Request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [BLK_W-1:0]  block_number_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BLK_W-1:0]  allocated_block_o,
  output logic [STAT_W-1:0] status_o
);

  `include "assert_macros.svh"

  // Bitmap size: blocks past the field reach can never be addressed
  localparam int unsigned ALL_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned CAP_WORDS = FIELD_LIMIT / WORD_W;
  localparam int unsigned MEM_WORDS = (ALL_WORDS < CAP_WORDS) ? ALL_WORDS : CAP_WORDS;
  localparam int unsigned AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CAP_BLKS  = (NUM_BLOCKS < FIELD_LIMIT) ? NUM_BLOCKS : FIELD_LIMIT;
  localparam logic [CFG_W-1:0] CAP      = CFG_W'(CAP_BLKS);
  localparam logic [AW-1:0]    LAST_MEM = AW'(MEM_WORDS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   total_blocks_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [AW-1:0]      word_q, word_d;
  logic               cmd_q;
  logic [BLK_W-1:0]   blk_q;
  logic [BLK_W-1:0]   res_blk_q, res_blk_d;
  status_e            res_stat_q, res_stat_d;
  logic               out_valid_q, out_valid_d;
  logic [BLK_W-1:0]   out_blk_q;
  status_e            out_stat_q;

  // Bitmap RAM ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;

  // Scan helpers
  logic [CFG_W-1:0]   lim;
  logic [BLK_W-1:0]   lim_m1;
  logic [WIDX_W-1:0]  last_word;
  logic               at_last;
  logic [WORD_W-1:0]  word_mask;
  logic [WORD_W-1:0]  free_bits;
  logic               free_any;
  logic [BIT_W-1:0]   free_idx;
  logic               in_acc;
  logic               slot_free;
  logic [AW-1:0]      in_word;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Active block count, capped by the bitmap size and field reach
  assign lim       = (total_blocks_q > CAP) ? CAP : total_blocks_q;
  assign lim_m1    = BLK_W'(lim - CFG_W'(1));
  assign last_word = lim_m1[BLK_W-1:BIT_W];
  assign at_last   = (WIDX_W'(word_q) == last_word);

  // Only bits below the count take part in the last word
  assign word_mask = at_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim_m1[BIT_W-1:0]))
                             : {WORD_W{1'b1}};
  assign free_bits = ~mem_rdata & word_mask;
  assign free_any  = |free_bits;

  // Lowest free bit of the current word
  always_comb begin
    free_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_idx = BIT_W'(i);
      end
    end
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_word   = AW'(block_number_i[BLK_W-1:BIT_W]);

  // Sequencer: clear, accept, read-modify-write, hand result over
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    word_d      = word_q;
    res_blk_d   = res_blk_q;
    res_stat_d  = res_stat_q;
    mem_we      = 1'b0;
    mem_waddr   = word_q;
    mem_wdata   = mem_rdata;
    mem_raddr   = word_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_MEM) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // The write of the previous request has landed; no overlap here
        word_d    = (cmd_i == CMD_FREE) ? in_word : '0;
        mem_raddr = word_d;
        res_blk_d = '0;
        if (in_acc) begin
          if (cmd_i == CMD_ALLOC && lim == '0) begin
            res_stat_d = ST_FULL;
            state_d    = S_RESP;
          end else if (cmd_i == CMD_FREE && {1'b0, block_number_i} >= lim) begin
            res_stat_d = ST_RANGE;
            state_d    = S_RESP;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        mem_raddr = word_q + AW'(1);
        if (cmd_q == CMD_ALLOC) begin
          if (free_any) begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata | (WORD_W'(1) << free_idx);
            res_blk_d  = {WIDX_W'(word_q), free_idx};
            res_stat_d = ST_OK;
            state_d    = S_RESP;
          end else if (at_last) begin
            res_stat_d = ST_FULL;
            state_d    = S_RESP;
          end else begin
            word_d = word_q + AW'(1);
          end
        end else begin
          if (mem_rdata[blk_q[BIT_W-1:0]]) begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
            res_stat_d = ST_OK;
          end else begin
            res_stat_d = ST_ALREADY_FREE;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      total_blocks_q <= TOTAL_BLOCKS_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_blocks_q <= cfg_wdata_i;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    res_blk_q  <= res_blk_d;
    res_stat_q <= res_stat_d;
    if (in_acc) begin
      cmd_q <= cmd_i;
      blk_q <= block_number_i;
    end
    if (state_q == S_RESP && slot_free) begin
      out_blk_q  <= res_blk_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_block_o = out_blk_q;
  assign status_o          = out_stat_q;

  // Requests are held off during the clearing pass
  `BBA_ASSERT(a_clear_stalls, (state_q == S_CLEAR) |-> in_stall_o, "request taken while clearing")
  // A new result appears only after the response state
  `BBA_ASSERT(a_out_from_resp, $rose(out_valid_q) |-> $past(state_q == S_RESP), "result without request")
  // No bitmap write while a read for the next request may issue
  `BBA_ASSERT(a_no_idle_write, (state_q == S_IDLE) |-> !mem_we, "bitmap write while idle")
  // The allocate scan never runs past the last word of the count
  `BBA_ASSERT(a_scan_bound, (state_q == S_EVAL && cmd_q == CMD_ALLOC) |-> (WIDX_W'(word_q) <= last_word), "scan beyond block count")

endmodule

### tb/bba_grant_checker.sv
// Grant checker for the block bitmap allocator: watches the config, request
// and result channels, predicts every result and compares. Depends on bba_pkg.
module bba_grant_checker
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              cmd_i,
  input  logic [BLK_W-1:0]  block_number_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [BLK_W-1:0]  allocated_block_i,
  input  logic [STAT_W-1:0] status_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_e          st;
  } grant_t;

  // Shadow of the usage bitmap and the block count register
  logic [NUM_BLOCKS_DEF-1:0] used_map;
  logic [CFG_W-1:0]          block_count;
  grant_t                    grant_q[$];
  int unsigned               fails;

  // First-fit allocate or free against the shadow bitmap
  function automatic grant_t next_grant(logic cmd, logic [BLK_W-1:0] blk);
    grant_t      g;
    int unsigned lim;
    int unsigned b;
    g.blk = '0;
    lim = block_count;
    if (lim > NUM_BLOCKS_DEF) lim = NUM_BLOCKS_DEF;
    if (lim > FIELD_LIMIT) lim = FIELD_LIMIT;
    if (cmd == CMD_ALLOC) begin
      g.st = ST_FULL;
      for (b = 0; b < lim; b++) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          g.blk = BLK_W'(b);
          g.st = ST_OK;
          break;
        end
      end
    end else if (blk >= lim) begin
      // also covers bits left set above a lowered count
      g.st = ST_RANGE;
    end else if (!used_map[blk]) begin
      g.st = ST_ALREADY_FREE;
    end else begin
      used_map[blk] = 1'b0;
      g.st = ST_OK;
    end
    return g;
  endfunction

  // Compare the result taken this edge, then predict the request taken
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      used_map = '0;
      block_count = TOTAL_BLOCKS_RST;
      grant_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) block_count = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: allocated_block %0d status %0d",
                 allocated_block_i, status_i);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (allocated_block_i !== want.blk) begin
            $error("allocated_block: expected %0d, got %0d", want.blk, allocated_block_i);
            fails++;
          end
          if (status_i !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) grant_q.push_back(next_grant(cmd_i, block_number_i));
      fail_count_o <= fails;
      pending_o <= grant_q.size();
    end
  end

endmodule

### tb/tb_block_bitmap_allocator_top.sv
// Testbench top for the block bitmap allocator: drives requests, block count
// writes and result stalls. Depends on bba_pkg, bba_grant_checker and the RTL.
module tb_block_bitmap_allocator_top;
  import bba_pkg::*;

  localparam int unsigned N_PHASES   = 11;
  localparam int unsigned PHASE_REQS = 150;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASE_BLOCKS [N_PHASES] =
    '{40, 4096, 1, 100, 8191, 0, 33, 64, 4095, 2, 300};

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              cmd_i;
  logic [BLK_W-1:0]  block_number_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BLK_W-1:0]  allocated_block_o;
  logic [STAT_W-1:0] status_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned req_count;
  int unsigned cfg_count;
  bit          hold_start;

  block_bitmap_allocator_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .block_number_i   (block_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .allocated_block_o(allocated_block_o),
    .status_o         (status_o)
  );

  bba_grant_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .block_number_i   (block_number_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .allocated_block_i(allocated_block_o),
    .status_i         (status_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Clock, period 12
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #(12 * 4_000_000);
    $display("tb_block_bitmap_allocator_top: errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Offer one request after a random gap and wait until it is taken
  task automatic send_req(input logic cmd, input logic [BLK_W-1:0] blk);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    block_number_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    req_count++;
  endtask

  // Wait until every result is back and the block is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_blocks(input int unsigned n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(n);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_count++;
  endtask

  // Free target: mostly near the low end where first-fit grants land,
  // some around the count boundary, some anywhere
  function automatic logic [BLK_W-1:0] pick_block(int unsigned cnt);
    int unsigned r;
    int unsigned b;
    r = $urandom_range(9);
    if (r < 6) begin
      b = $urandom_range((cnt > 80) ? 82 : cnt + 2);
    end else if (r < 8) begin
      b = cnt + $urandom_range(2);
      if (b > 0) b--;
    end else begin
      b = $urandom;
    end
    return BLK_W'(b);
  endfunction

  // Stimulus and verdict
  initial begin
    int unsigned cnt;
    logic        cmd;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_ALLOC;
    block_number_i = '0;
    hold_start = 1'b0;
    send_idle = 31;
    recv_idle = 64;
    req_count = 0;
    cfg_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default count, first-fit order, double free
    send_req(CMD_FREE, 12'd0);
    send_req(CMD_FREE, 12'd4095);
    send_req(CMD_ALLOC, 12'd4095);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_ALLOC, 12'd1234);
    send_req(CMD_FREE, 12'd1);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE, 12'd1);
    send_req(CMD_FREE, 12'd1);
    // Tiny count: exhaustion and range check
    set_blocks(3);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE, 12'd3);
    send_req(CMD_FREE, 12'd2);
    // Used bit above a lowered count is not freeable
    set_blocks(1);
    send_req(CMD_FREE, 12'd1);
    send_req(CMD_ALLOC, 12'd0);
    // Zero count
    set_blocks(0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE, 12'd0);
    // Oversized count clamps to the bitmap; old bit becomes freeable again
    set_blocks(8191);
    send_req(CMD_FREE, 12'd4095);
    send_req(CMD_FREE, 12'd1);
    send_req(CMD_ALLOC, 12'd4095);

    // Random phases across block counts and idle patterns
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      set_blocks(PHASE_BLOCKS[p]);
      if (p < 4) begin
        send_idle = 31;
        recv_idle = 64;
      end else if (p < 8) begin
        send_idle = 64;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // long receiver hold-off so the block backs up into the request side
      if (p == 8) hold_start = 1'b1;
      cnt = (PHASE_BLOCKS[p] > FIELD_LIMIT) ? FIELD_LIMIT : PHASE_BLOCKS[p];
      for (int unsigned i = 0; i < PHASE_REQS; i++) begin
        cmd = ($urandom_range(99) < 55) ? CMD_ALLOC : CMD_FREE;
        send_req(cmd, (cmd == CMD_ALLOC) ? BLK_W'($urandom) : pick_block(cnt));
      end
    end
    drain();

    $display("Covered %0d allocate/free requests across %0d block count writes,",
             req_count, cfg_count);
    $display("including zero, one, the full bitmap and an oversized count.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_block_bitmap_allocator_top: clean");
    end else begin
      $display("tb_block_bitmap_allocator_top: errors");
    end
    $finish;
  end

endmodule
